// ===== hw/rtl/bspq_pkg.sv =====
// Package for the bounded stable priority queue.
// Holds field widths, request and status codes and the stored slot type.
// No dependencies.
package bspq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int PRI_W    = 4;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } slot_t;

endpackage

// ===== hw/rtl/bspq_slot_ram.sv =====
// Slot store of the priority queue: one write port, one registered read port.
// Depends on bspq_pkg (slot_t).
module bspq_slot_ram #(
  parameter int DEPTH  = bspq_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  bspq_pkg::slot_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output bspq_pkg::slot_t     rd_data
);

  bspq_pkg::slot_t mem [DEPTH];
  bspq_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/bounded_stable_priority_queue_unit.sv =====
// Top level of the bounded stable priority queue.
// Sequencer, result register and one shared priority compare around bspq_slot_ram.
// Depends on bspq_pkg and bspq_slot_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------------
//  in_     | input     | in_valid / in_stall  | in_req_type, in_entry_priority, in_entry_tag
//  out_    | output    | out_valid/ out_stall | out_status, out_priority, out_tag,
//          |           |                      | out_entry_count
//
// Steps after the input transfer: a refused insert, an empty pop or an insert into an
// empty queue go straight to S_EMIT; an insert walks S_INS_CMP over each stored entry it
// moves up, then S_INS_LAST if it reaches the head; a pop reads the head in S_POP_HEAD,
// and S_POP_MV closes the gap; the slot RAM moves one entry per cycle.
// Reset clears the sequencer, the count and the result valid flag; the slot RAM is not
// cleared, since only slots below the count are ever read.
// in_stall is high while a request is being worked on; the next request is taken while
// a finished result still waits in the output register.
module bounded_stable_priority_queue_unit #(
  parameter int CAPACITY = bspq_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [bspq_pkg::PRI_W-1:0]     in_entry_priority,
  input  logic [bspq_pkg::TAG_W-1:0]     in_entry_tag,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bspq_pkg::STATUS_W-1:0]  out_status,
  output logic [bspq_pkg::PRI_W-1:0]     out_priority,
  output logic [bspq_pkg::TAG_W-1:0]     out_tag,
  output logic [bspq_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,   // walk from the tail toward the head, one slot a cycle
    S_INS_LAST,  // new entry lands in the head slot
    S_POP_HEAD,  // head slot read data is the popped entry
    S_POP_MV,    // close the gap, one slot a cycle
    S_EMIT       // hand the result to the output register
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                idx_r, idx_nxt;
  bspq_pkg::slot_t                 req_r, req_nxt;
  logic [bspq_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  bspq_pkg::slot_t                 res_slot_r, res_slot_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [bspq_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  bspq_pkg::slot_t                 out_slot_r, out_slot_nxt;
  logic [bspq_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  // slot RAM controls
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  bspq_pkg::slot_t                 wr_data;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  bspq_pkg::slot_t                 rd_data;

  logic                            in_xfer;
  logic                            out_free;
  logic                            pri_keep;   // shared compare: stored entry stays ahead
  logic [CNT_W-1:0]                idx_m1;
  logic [CNT_W-1:0]                idx_p1;
  logic [CNT_W-1:0]                cnt_m1;
  logic [CNT_W+bspq_pkg::COUNT_W-1:0] cnt_ext;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign pri_keep = (rd_data.pri >= req_r.pri);
  assign idx_m1   = idx_r - CNT_ONE;
  assign idx_p1   = idx_r + CNT_ONE;
  assign cnt_m1   = cnt_r - CNT_ONE;
  assign cnt_ext  = {{bspq_pkg::COUNT_W{1'b0}}, cnt_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r[IDX_W-1:0];
    wr_data        = req_r;
    rd_en          = 1'b0;
    rd_addr        = idx_m1[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt.pri    = in_entry_priority;
          req_nxt.tag    = in_entry_tag;
          res_status_nxt = bspq_pkg::STATUS_DONE;
          res_slot_nxt   = '0;
          if (in_req_type == bspq_pkg::REQ_INSERT) begin
            if (cnt_r == CNT_FULL) begin
              res_status_nxt = bspq_pkg::STATUS_FULL;
              state_nxt      = S_EMIT;
            end else if (cnt_r == '0) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = req_nxt;
              cnt_nxt   = CNT_ONE;
              state_nxt = S_EMIT;
            end else begin
              // start at the tail: read the last stored entry
              rd_en     = 1'b1;
              rd_addr   = cnt_m1[IDX_W-1:0];
              idx_nxt   = cnt_r;
              state_nxt = S_INS_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              res_status_nxt = bspq_pkg::STATUS_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = CNT_ONE;
              state_nxt = S_POP_HEAD;
            end
          end
        end
      end

      S_INS_CMP: begin
        // rd_data holds slot[idx-1]; idx is the free slot
        wr_en   = 1'b1;
        wr_addr = idx_r[IDX_W-1:0];
        if (pri_keep) begin
          wr_data   = req_r;
          cnt_nxt   = cnt_r + CNT_ONE;
          state_nxt = S_EMIT;
        end else begin
          wr_data = rd_data;
          idx_nxt = idx_m1;
          if (idx_m1 == '0) begin
            state_nxt = S_INS_LAST;
          end else begin
            rd_en   = 1'b1;
            rd_addr = 
              IDX_W'(idx_m1 - CNT_ONE);
          end
        end
      end

      S_INS_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = req_r;
        cnt_nxt   = cnt_r + CNT_ONE;
        state_nxt = S_EMIT;
      end

      S_POP_HEAD: begin
        res_slot_nxt = rd_data;
        if (cnt_r == CNT_ONE) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r[IDX_W-1:0];
          state_nxt = S_POP_MV;
        end
      end

      S_POP_MV: begin
        // rd_data holds slot[idx]; move it down one place
        wr_en   = 1'b1;
        wr_addr = idx_m1[IDX_W-1:0];
        wr_data = rd_data;
        if (idx_p1 == cnt_r) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[IDX_W-1:0];
          idx_nxt = idx_p1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = cnt_ext[bspq_pkg::COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  bspq_slot_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_priority    = out_slot_r.pri;
  assign out_tag         = out_slot_r.tag;
  assign out_entry_count = out_count_r;

endmodule

// ===== hw/rtl/bspq_checker.sv =====
// Port-level checks for the priority queue top level, and the bind that attaches them.
// Depends on bspq_pkg and bounded_stable_priority_queue_unit.
module bspq_checker #(
  parameter int CAPACITY = bspq_pkg::CAPACITY_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bspq_pkg::STATUS_W-1:0]  out_status,
  input logic [bspq_pkg::PRI_W-1:0]     out_priority,
  input logic [bspq_pkg::TAG_W-1:0]     out_tag,
  input logic [bspq_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam logic [bspq_pkg::COUNT_W-1:0] FULL_CNT = bspq_pkg::COUNT_W'(CAPACITY);

  // every accepted request keeps the block busy: in_stall is high after the transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request channel not stalled after a transfer");

  // a refused insert reports a full queue and no entry
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bspq_pkg::STATUS_FULL) |->
      (out_entry_count == FULL_CNT && out_priority == '0 && out_tag == '0))
    else $error("full status with wrong count or payload");

  // an empty pop reports a count of zero and no entry
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bspq_pkg::STATUS_EMPTY) |->
      (out_entry_count == '0 && out_priority == '0 && out_tag == '0))
    else $error("empty status with wrong count or payload");

  // a completed pop that returns a nonzero entry leaves at most CAPACITY-1 entries
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bspq_pkg::STATUS_DONE && CAPACITY < 32 &&
     (out_priority != '0 || out_tag != '0)) |-> (out_entry_count != FULL_CNT))
    else $error("pop result reports a full queue");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_priority) &&
       $stable(out_tag) && $stable(out_entry_count)))
    else $error("stalled result changed");

endmodule

bind bounded_stable_priority_queue_unit bspq_checker #(.CAPACITY(CAPACITY)) u_bspq_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for bounded_stable_priority_queue_unit.
// A queue predictor checks insert/pop ordering, full/empty status and counts.
// Depends on bspq_pkg and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP         = bspq_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS  = 1250;
  localparam int PRI_W       = bspq_pkg::PRI_W;
  localparam int TAG_W       = bspq_pkg::TAG_W;
  localparam int STATUS_W    = bspq_pkg::STATUS_W;
  localparam int COUNT_W     = bspq_pkg::COUNT_W;
  localparam int SETTLE_CYCLES = CAP + 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRI_W-1:0]    pri;
    logic [TAG_W-1:0]    tag;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_HOLD} flow_mode_e;

  // Tracks queue contents and the results still owed by the block.
  class pq_tracker;
    bspq_pkg::slot_t held[$];
    outcome_t        awaited[$];
    int              mismatches;
    int              n_insert, n_pop, n_full, n_empty, n_results;

    function void note_request(logic req, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag);
      outcome_t        o;
      bspq_pkg::slot_t s;
      int              pos;
      o.status = bspq_pkg::STATUS_DONE;
      o.pri    = '0;
      o.tag    = '0;
      if (req == bspq_pkg::REQ_INSERT) begin
        if (held.size() >= CAP) begin
          o.status = bspq_pkg::STATUS_FULL;
          n_full++;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < held.size() && held[pos].pri >= pri) pos++;
          s.pri = pri;
          s.tag = tag;
          held.insert(pos, s);
          n_insert++;
        end
      end else begin
        if (held.size() == 0) begin
          o.status = bspq_pkg::STATUS_EMPTY;
          n_empty++;
        end else begin
          s     = held.pop_front();
          o.pri = s.pri;
          o.tag = s.tag;
          n_pop++;
        end
      end
      o.count = COUNT_W'(held.size());
      awaited.push_back(o);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [PRI_W-1:0] pri,
                               logic [TAG_W-1:0] tag, logic [COUNT_W-1:0] count);
      outcome_t o;
      n_results++;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing awaited: status %0d tag %h", status, tag);
        mismatches++;
        return;
      end
      o = awaited.pop_front();
      if (status !== o.status) begin
        $error("out_status: expected %0d, got %0d", o.status, status);
        mismatches++;
      end
      if (pri !== o.pri) begin
        $error("out_priority: expected %0d, got %0d", o.pri, pri);
        mismatches++;
      end
      if (tag !== o.tag) begin
        $error("out_tag: expected %h, got %h", o.tag, tag);
        mismatches++;
      end
      if (count !== o.count) begin
        $error("out_entry_count: expected %0d, got %0d", o.count, count);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [PRI_W-1:0]    in_entry_priority;
  logic [TAG_W-1:0]    in_entry_tag;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [PRI_W-1:0]    out_priority;
  logic [TAG_W-1:0]    out_tag;
  logic [COUNT_W-1:0]  out_entry_count;

  pq_tracker  tracker = new();
  int         burst_left = 0;
  int         seg_left   = 0;
  flow_mode_e flow_mode  = FLOW_FREE;

  bounded_stable_priority_queue_unit #(.CAPACITY(CAP)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_entry_priority(in_entry_priority),
    .in_entry_tag     (in_entry_tag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_priority     (out_priority),
    .out_tag          (out_tag),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: both channels sampled at the edge, pre-update values.
  // A result never belongs to a request accepted on the same edge,
  // so checking before noting is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_result(out_status, out_priority, out_tag, out_entry_count);
      if (in_valid && !in_stall)
        tracker.note_request(in_req_type, in_entry_priority, in_entry_tag);
    end
  end

  // Receiver back-pressure: segments of free flow, light or heavy random
  // stalls, and solid holds.
  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_left  <= $urandom_range(1, 40);
      flow_mode <= flow_mode_e'($urandom_range(0, 3));
    end else begin
      seg_left <= seg_left - 1;
    end
    case (flow_mode)
      FLOW_FREE:  out_stall <= 1'b0;
      FLOW_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      FLOW_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= 1'b1;
    endcase
  end

  // Hold the request until a transfer happens. Called right after an edge.
  task automatic push_request(logic req, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag);
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_entry_priority <= pri;
    in_entry_tag      <= tag;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender pacing: bursts of back-to-back requests separated by idle gaps.
  // valid is lowered only here during the run, never in the same step it is raised.
  task automatic issue(logic req, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push_request(req, pri, tag);
    burst_left--;
  endtask

  task automatic run_directed();
    int i;
    issue(bspq_pkg::REQ_POP, 4'd9, 16'h1234);          // pop on empty queue
    issue(bspq_pkg::REQ_INSERT, 4'd15, 16'hFFFF);
    issue(bspq_pkg::REQ_INSERT, 4'd0, 16'h0000);
    issue(bspq_pkg::REQ_INSERT, 4'd7, 16'h1111);
    issue(bspq_pkg::REQ_INSERT, 4'd7, 16'h2222);       // equal priority must queue behind
    issue(bspq_pkg::REQ_INSERT, 4'd15, 16'h0001);      // ties the head
    issue(bspq_pkg::REQ_INSERT, 4'd0, 16'hFFFE);       // ties the tail
    for (i = 0; i < CAP - 6; i++)
      issue(bspq_pkg::REQ_INSERT, PRI_W'((i * 5) % 16), (i % 2) ? 16'hA5A5 : 16'h5A5A);
    issue(bspq_pkg::REQ_INSERT, 4'd15, 16'hFFFF);      // refused at capacity
    repeat (4) issue(bspq_pkg::REQ_POP, 4'd0, 16'h0000);
  endtask

  // Random phases with a chosen insert share drive the queue from empty to
  // full and back; narrow priority ranges produce many ties.
  task automatic run_random();
    int               sent;
    int               phase_len;
    int               insert_pct;
    bit               narrow;
    logic [PRI_W-1:0] base;
    logic [PRI_W-1:0] pri;
    logic             req;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0:       insert_pct = 20;
        1:       insert_pct = 50;
        2:       insert_pct = 80;
        default: insert_pct = 95;
      endcase
      narrow = 1'($urandom_range(0, 1));
      base   = PRI_W'($urandom_range(0, 14));
      repeat (phase_len) begin
        req = ($urandom_range(0, 99) < insert_pct) ? bspq_pkg::REQ_INSERT : bspq_pkg::REQ_POP;
        pri = narrow ? PRI_W'(base + $urandom_range(0, 1)) : PRI_W'($urandom_range(0, 15));
        issue(req, pri, TAG_W'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  initial begin
    int drain;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= bspq_pkg::REQ_INSERT;
    in_entry_priority <= '0;
    in_entry_tag      <= '0;
    out_stall         <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random();
    in_valid <= 1'b0;

    drain = 0;
    while (tracker.awaited.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    // catch any stray result the block might still produce
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.awaited.size() != 0) begin
      $error("%0d results never arrived", tracker.awaited.size());
      tracker.mismatches += tracker.awaited.size();
    end

    $display("covered %0d inserts, %0d pops, %0d refused full, %0d empty pops",
             tracker.n_insert, tracker.n_pop, tracker.n_full, tracker.n_empty);
    $display("%0d results checked, %0d mismatches", tracker.n_results, tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout: simulation limit reached");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bspq_pkg.sv
hw/rtl/bspq_slot_ram.sv
hw/rtl/bounded_stable_priority_queue_unit.sv
hw/rtl/bspq_checker.sv
tb/testbench.sv
